/* hw/rtl/vpk_pkg.sv */
// Shared constants and types of the VP8 RTP packetizer.
// No dependencies; every other file imports this package.
`default_nettype none

package vpk_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned PICID_W   = 7;
    localparam int unsigned RUN_LEN   = 4;
    localparam int unsigned RUN_IDX_W = 2;

    localparam logic [BYTE_W-1:0]  DESC_X          = 8'h80;
    localparam logic [BYTE_W-1:0]  DESC_S          = 8'h10;
    localparam logic [BYTE_W-1:0]  DESC_I          = 8'h80;
    localparam logic [LEN_W-1:0]   MIN_PAYLOAD     = 16'd4;
    localparam logic [LEN_W-1:0]   RST_MAX_PAYLOAD = 16'd1200;
    localparam logic [LEN_W-1:0]   DESC_LEN        = 16'd3;

    // First slot of a run: full descriptor run or frame byte alone
    localparam logic [RUN_IDX_W-1:0] IDX_DESC0 = 2'd0;
    localparam logic [RUN_IDX_W-1:0] IDX_DATA  = 2'd3;

    // One run of results caused by one input item
    typedef struct packed {
        logic [RUN_LEN-1:0][BYTE_W-1:0] payload;
        logic [RUN_IDX_W-1:0]           start_idx;
        logic                           pkt_end;
        logic                           marker;
        logic                           key;
    } t_run;

endpackage

`default_nettype wire

/* hw/rtl/vpk_if.sv */
// Channel interfaces of the VP8 RTP packetizer: frame input, payload
// output and configuration write. Depends on vpk_pkg.
`default_nettype none

interface vpk_in_if;
    import vpk_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;
    logic              is_keyframe;
    modport source (output valid, frame_byte, frame_last, is_keyframe, input ready);
    modport sink   (input valid, frame_byte, frame_last, is_keyframe, output ready);
endinterface

interface vpk_out_if;
    import vpk_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              packet_end;
    logic              rtp_marker;
    logic              keyframe_packet;
    logic              run_last;
    modport source (output valid, payload_byte, packet_end, rtp_marker,
                    keyframe_packet, run_last, input ready);
    modport sink   (input valid, payload_byte, packet_end, rtp_marker,
                    keyframe_packet, run_last, output ready);
endinterface

interface vpk_cfg_if;
    import vpk_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_payload;
    modport source (output valid, max_payload, input ready);
    modport sink   (input valid, max_payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vpk_core.sv */
// Input register, packetizer state and run builder.
// Depends on vpk_pkg and vpk_if.
`default_nettype none

module vpk_core
    import vpk_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vpk_in_if.sink     i_in,
    vpk_cfg_if.sink    i_cfg,
    output t_run       o_run,
    output logic       o_run_valid,
    input  wire logic  i_run_ready
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_key;

    logic [LEN_W-1:0]   r_max_payload;
    logic               r_at_frame_start;
    logic               r_packet_open;
    logic [LEN_W-1:0]   r_bytes_in_packet;
    logic [PICID_W-1:0] r_picture_id;
    logic               r_first_packet;
    logic               r_frame_is_key;

    logic               load;
    logic               key_eff;
    logic               first_eff;
    logic [LEN_W-1:0]   limit;
    logic [LEN_W-1:0]   cnt;
    logic               pkt_end;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_in_valid || i_run_ready;
    assign load        = r_in_valid && i_run_ready;
    assign o_run_valid = r_in_valid;

    always_comb begin
        key_eff   = r_at_frame_start ? r_key : r_frame_is_key;
        first_eff = r_at_frame_start || r_first_packet;
        limit     = (r_max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : r_max_payload;
        cnt       = (r_packet_open ? r_bytes_in_packet : DESC_LEN) + LEN_W'(1);
        pkt_end   = r_last || (cnt >= limit);

        o_run.payload[0] = DESC_X | (first_eff ? DESC_S : '0);
        o_run.payload[1] = DESC_I;
        o_run.payload[2] = {1'b0, r_picture_id};
        o_run.payload[3] = r_byte;
        o_run.start_idx  = r_packet_open ? IDX_DATA : IDX_DESC0;
        o_run.pkt_end    = pkt_end;
        o_run.marker     = r_last;
        o_run.key        = first_eff && key_eff;
    end

    // Input register: hold the item until the serialiser takes its run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.frame_byte;
            r_last <= i_in.frame_last;
            r_key  <= i_in.is_keyframe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload     <= RST_MAX_PAYLOAD;
            r_at_frame_start  <= 1'b1;
            r_packet_open     <= 1'b0;
            r_bytes_in_packet <= '0;
            r_picture_id      <= '0;
            r_first_packet    <= 1'b1;
            r_frame_is_key    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_max_payload <= i_cfg.max_payload;
            end
            if (load) begin
                r_at_frame_start  <= r_last;
                r_frame_is_key    <= key_eff;
                r_packet_open     <= !pkt_end;
                r_bytes_in_packet <= pkt_end ? '0 : cnt;
                r_first_packet    <= r_last || (first_eff && !pkt_end);
                if (r_last) begin
                    r_picture_id <= r_picture_id + PICID_W'(1);
                end
            end
        end
    end

    a_closed_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_packet_open |-> r_bytes_in_packet == '0)
        else $error("byte count not cleared on a closed packet");

    a_open_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && !pkt_end |=> r_packet_open && r_bytes_in_packet >= DESC_LEN + LEN_W'(1))
        else $error("open packet with a short byte count");

    a_frame_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_last |=> r_at_frame_start && r_first_packet && !r_packet_open)
        else $error("frame end did not reset the packet state");

endmodule

`default_nettype wire

/* hw/rtl/vpk_serializer.sv */
// Result register: holds one run and emits its results one per cycle while the output is ready.
// Depends on vpk_pkg and vpk_if.
`default_nettype none

module vpk_serializer
    import vpk_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_run  i_run,
    input  wire logic  i_run_valid,
    output logic       o_run_ready,
    vpk_out_if.source  o_out
);

    logic                 r_valid;
    t_run                 r_run;
    logic [RUN_IDX_W-1:0] r_idx;
    logic                 at_last;
    logic                 take;

    assign at_last     = (r_idx == IDX_DATA);
    assign take        = r_valid && o_out.ready;
    assign o_run_ready = !r_valid || (take && at_last);

    assign o_out.valid           = r_valid;
    assign o_out.payload_byte    = r_run.payload[r_idx];
    assign o_out.packet_end      = at_last && r_run.pkt_end;
    assign o_out.rtp_marker      = at_last && r_run.marker;
    assign o_out.keyframe_packet = r_run.key;
    assign o_out.run_last        = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= IDX_DESC0;
        end else if (i_run_valid && o_run_ready) begin
            r_valid <= 1'b1;
            r_idx   <= i_run.start_idx;
        end else if (take) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + RUN_IDX_W'(1);
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_run_valid && o_run_ready) begin
            r_run <= i_run;
        end
    end

    a_end_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.packet_end || o_out.rtp_marker |-> o_out.run_last)
        else $error("packet end flag away from the run's last result");

    a_desc_has_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_idx == IDX_DESC0 |-> o_out.payload_byte[BYTE_W-1])
        else $error("descriptor byte without X bit");

    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.rtp_marker |-> o_out.packet_end)
        else $error("marker without packet end");

endmodule

`default_nettype wire

/* hw/rtl/vp8_rtp_packetizer.sv */
// VP8 RTP packetizer top level. An accepted byte passes the input register in
// vpk_core, then the result register in vpk_serializer. Throughput: one input
// item per cycle while each gives one result and the output is ready; an item
// that opens a packet holds the input until its descriptor and data are emitted.
// Sync active-low reset clears control state; max_payload returns to 1200.
// Depends on vpk_pkg, vpk_if, vpk_core and vpk_serializer.
`default_nettype none

module vp8_rtp_packetizer
    import vpk_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vpk_in_if.sink    i_in,
    vpk_cfg_if.sink   i_cfg,
    vpk_out_if.source o_out
);

    t_run run;
    logic run_valid;
    logic run_ready;

    vpk_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_run       (run),
        .o_run_valid (run_valid),
        .i_run_ready (run_ready)
    );

    vpk_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (run),
        .i_run_valid (run_valid),
        .o_run_ready (run_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* tb/vp8_rtp_packetizer_tb.sv */
// Self-checking testbench of the VP8 RTP packetizer: random and directed frames
// against an in-bench packetizer model, with random stalls on both channels.
// Depends on vpk_pkg, vpk_if and the vp8_rtp_packetizer top level.
`default_nettype none

module vp8_rtp_packetizer_tb;
    import vpk_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 11;
    // The limit covers the slowest correct run: four results per byte, each behind
    // a stall burst, plus sender gaps and the long hold-off.
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 5;
    localparam int PHASE_ITEMS      = 36;
    localparam int WRAP_FRAMES      = 135;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              key;
    } t_frame_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              pkt_end;
        logic              marker;
        logic              key;
        logic              run_last;
    } t_payload_item;

    logic clk;
    logic rst_n;

    vpk_in_if  in_ch ();
    vpk_cfg_if cfg_ch ();
    vpk_out_if out_ch ();

    vp8_rtp_packetizer u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_frame_item   pending_bytes[$];
    t_payload_item expected_payload[$];

    // Packetizer model state
    logic [LEN_W-1:0]   max_payload_q;
    logic               at_frame_start_q;
    logic               packet_open_q;
    logic [LEN_W-1:0]   pkt_len_q;
    logic [PICID_W-1:0] pic_id_q;
    logic               first_packet_q;
    logic               frame_key_q;

    int  items_in;
    int  errors;
    int  cycle_count;
    int  send_gap;
    int  stall_left;
    int  frame_left;
    int  frames_sent;
    bit  idle_on;
    bit  long_hold_done;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic t_payload_item payload_of(input logic [BYTE_W-1:0] data,
                                                 input logic pkt_end, input logic marker,
                                                 input logic key, input logic run_last);
        t_payload_item r;
        r.data     = data;
        r.pkt_end  = pkt_end;
        r.marker   = marker;
        r.key      = key;
        r.run_last = run_last;
        return r;
    endfunction

    task automatic packetize_byte(input logic [BYTE_W-1:0] data, input logic last,
                                  input logic key_in);
        logic [LEN_W-1:0] limit;
        logic             key;
        logic             close;
        limit = (max_payload_q < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_q;
        if (at_frame_start_q) begin
            frame_key_q      = key_in;
            first_packet_q   = 1'b1;
            at_frame_start_q = 1'b0;
        end
        key = first_packet_q & frame_key_q;
        if (!packet_open_q) begin
            expected_payload.push_back(payload_of(DESC_X | (first_packet_q ? DESC_S : 8'h00),
                                                  1'b0, 1'b0, key, 1'b0));
            expected_payload.push_back(payload_of(DESC_I, 1'b0, 1'b0, key, 1'b0));
            expected_payload.push_back(payload_of({1'b0, pic_id_q}, 1'b0, 1'b0, key, 1'b0));
            packet_open_q = 1'b1;
            pkt_len_q     = DESC_LEN;
        end
        pkt_len_q = pkt_len_q + 1'b1;
        close     = last || (pkt_len_q >= limit);
        expected_payload.push_back(payload_of(data, close, last, key, 1'b1));
        if (close) begin
            packet_open_q  = 1'b0;
            pkt_len_q      = '0;
            first_packet_q = 1'b0;
        end
        if (last) begin
            at_frame_start_q = 1'b1;
            first_packet_q   = 1'b1;
            pic_id_q         = pic_id_q + 1'b1;
        end
    endtask

    task automatic push_item(input logic [BYTE_W-1:0] data, input logic last,
                             input logic key);
        t_frame_item it;
        it.data = data;
        it.last = last;
        it.key  = key;
        if (last)
            frames_sent++;
        pending_bytes.push_back(it);
    endtask

    // Frames carry over from one call to the next; an open frame is continued.
    task automatic queue_frames(input int n_items, input bit single_byte);
        logic key;
        for (int i = 0; i < n_items; i++) begin
            if (frame_left == 0) begin
                if (single_byte)
                    frame_left = 1;
                else
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: frame_left = $urandom_range(1, 3);
                        4, 5, 6, 7: frame_left = $urandom_range(4, 12);
                        default:    frame_left = $urandom_range(13, 40);
                    endcase
                key = ($urandom_range(0, 9) < 4);
            end else begin
                // ignored past the first byte
                key = 1'($urandom_range(0, 1));
            end
            push_item(BYTE_W'($urandom_range(0, 255)), frame_left == 1, key);
            frame_left--;
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_ch.valid || expected_payload.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_payload(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.max_payload <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid  <= 1'b0;
        max_payload_q  = value;
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Input driver: hold each item until taken, then maybe idle for a burst
    always @(posedge clk) begin
        t_frame_item it;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                packetize_byte(in_ch.frame_byte, in_ch.frame_last, in_ch.is_keyframe);
                items_in <= items_in + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    it = pending_bytes.pop_front();
                    in_ch.frame_byte  <= it.data;
                    in_ch.frame_last  <= it.last;
                    in_ch.is_keyframe <= it.key;
                    in_ch.valid       <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 13);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stall bursts, and one long hold-off while bytes wait
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (!long_hold_done && items_in >= LONG_HOLD_AT && pending_bytes.size() > 20) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        t_payload_item want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_payload.size() == 0) begin
                $error("payload item with nothing expected: byte %0h", out_ch.payload_byte);
                errors++;
            end else begin
                want = expected_payload.pop_front();
                check_field("payload_byte", want.data, out_ch.payload_byte);
                check_field("packet_end", BYTE_W'(want.pkt_end),
                            BYTE_W'(out_ch.packet_end));
                check_field("rtp_marker", BYTE_W'(want.marker),
                            BYTE_W'(out_ch.rtp_marker));
                check_field("keyframe_packet", BYTE_W'(want.key),
                            BYTE_W'(out_ch.keyframe_packet));
                check_field("run_last", BYTE_W'(want.run_last),
                            BYTE_W'(out_ch.run_last));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [LEN_W-1:0] phase_max [RANDOM_PHASES];

        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.frame_byte   = '0;
        in_ch.frame_last   = 1'b0;
        in_ch.is_keyframe  = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.max_payload = '0;
        out_ch.ready       = 1'b0;

        max_payload_q    = RST_MAX_PAYLOAD;
        at_frame_start_q = 1'b1;
        packet_open_q    = 1'b0;
        pkt_len_q        = '0;
        pic_id_q         = '0;
        first_packet_q   = 1'b1;
        frame_key_q      = 1'b0;

        items_in       = 0;
        errors         = 0;
        cycle_count    = 0;
        send_gap       = 0;
        stall_left     = 0;
        frame_left     = 0;
        frames_sent    = 0;
        idle_on        = 1'b1;
        long_hold_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit: keyframe, one-byte frame, then a frame left open
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'ha5, 1'b1, 1'b0);
        push_item(8'h3c, 1'b1, 1'b0);
        push_item(8'h01, 1'b0, 1'b1);
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'h7f, 1'b0, 1'b0);
        wait_drained();

        // Lower the limit under the open packet: close on the next byte
        write_max_payload(MIN_PAYLOAD);
        push_item(8'h55, 1'b0, 1'b0);
        push_item(8'haa, 1'b1, 1'b1);
        push_item(8'h11, 1'b0, 1'b1);
        push_item(8'h22, 1'b0, 1'b0);
        push_item(8'h33, 1'b1, 1'b1);
        wait_drained();

        // Limits below the minimum act as the minimum
        write_max_payload(16'd0);
        push_item(8'hfe, 1'b0, 1'b0);
        push_item(8'h02, 1'b1, 1'b1);
        wait_drained();
        write_max_payload(16'd3);
        push_item(8'h40, 1'b0, 1'b1);
        push_item(8'hbf, 1'b1, 1'b0);
        wait_drained();

        phase_max[0] = 16'hffff;
        phase_max[1] = LEN_W'($urandom_range(5, 8));
        phase_max[2] = LEN_W'($urandom_range(9, 30));
        phase_max[3] = MIN_PAYLOAD;
        phase_max[4] = LEN_W'($urandom_range(0, 3));
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = (p != 2);
            write_max_payload(phase_max[p]);
            queue_frames(PHASE_ITEMS, 1'b0);
            wait_drained();
        end

        // Run of one-byte frames, no idling: carry the picture id past its wrap
        idle_on = 1'b0;
        write_max_payload(RST_MAX_PAYLOAD);
        queue_frames(frame_left, 1'b0);
        queue_frames((WRAP_FRAMES - frames_sent > 60) ? WRAP_FRAMES - frames_sent : 60, 1'b1);
        wait_drained();
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
